>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

>>> src/tws_pkg.sv
`timescale 1ns / 1ps

package tws_pkg;

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    // output byte source
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_HEAD = 2'd0;  // oldest held blank
    localparam t_sel SEL_CHAR = 2'd1;  // held input byte
    localparam t_sel SEL_NL   = 2'd2;  // newline

    typedef struct packed {
        logic load_item;
        logic emit;
        t_sel emit_sel;
        logic emit_last;
        logic emit_forced;
        logic push;
        logic pop;
        logic drop;
        logic set_lhc;
        logic clr_lhc;
    } t_cmd;

    typedef struct packed {
        logic is_ws;
        logic is_nl;
        logic eos;
        logic lhc;
        logic full;
        logic empty;
        logic count_one;
        logic out_free;
    } t_sts;

endpackage

>>> src/tws_ram.sv
`timescale 1ns / 1ps

module tws_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/tws_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tws_datapath #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tws_pkg::t_cmd  i_cmd,
    output tws_pkg::t_sts  o_sts,
    input  logic [7:0]     i_in_char,
    input  logic           i_in_end_of_stream,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_out_char,
    output logic           o_out_last_of_run,
    output logic           o_out_forced_flush
);
    import tws_pkg::*;

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int SW = CW + 1;

    // held item
    logic [7:0]    r_char;
    logic          r_eos;
    logic          r_lhc, n_lhc;

    // blank queue pointers
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] head_inc;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;

    // read-during-write forward
    logic          r_byp;
    logic          r_byp_kind;
    logic          ram_kind;
    logic          head_kind;
    logic          wr_kind;

    // output register
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_last;
    logic          r_out_forced;
    logic [7:0]    emit_char;
    logic          out_free;

    assign head_inc = (r_head == AW'(PENDING_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail     = (tail_sum >= SW'(PENDING_DEPTH)) ?
                      AW'(tail_sum - SW'(PENDING_DEPTH)) : AW'(tail_sum);
    assign wr_kind  = (r_char == CH_TAB);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.pop) begin
            n_head = head_inc;
        end
        if (i_cmd.drop) begin
            n_count = '0;
        end else if (i_cmd.push && !i_cmd.pop) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_count = r_count - CW'(1);
        end
        n_lhc = r_lhc;
        if (i_cmd.set_lhc) begin
            n_lhc = 1'b1;
        end else if (i_cmd.clr_lhc) begin
            n_lhc = 1'b0;
        end
    end

    // read address is the next head pointer so the head entry is always on hand
    tws_ram #(
        .WIDTH (1),
        .DEPTH (PENDING_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (tail),
        .i_wr_data (wr_kind),
        .i_rd_addr (n_head),
        .o_rd_data (ram_kind)
    );

    assign head_kind = r_byp ? r_byp_kind : ram_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_lhc   <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_lhc   <= n_lhc;
            r_byp   <= i_cmd.push && (tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_kind <= wr_kind;
        if (i_cmd.load_item) begin
            r_char <= i_in_char;
            r_eos  <= i_in_end_of_stream;
        end
    end

    always_comb begin
        case (i_cmd.emit_sel)
            SEL_HEAD: emit_char = head_kind ? CH_TAB : CH_SPACE;
            SEL_CHAR: emit_char = r_char;
            SEL_NL:   emit_char = CH_NEWLINE;
            default:  emit_char = CH_NEWLINE;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char   <= emit_char;
            r_out_last   <= i_cmd.emit_last;
            r_out_forced <= i_cmd.emit_forced;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_char         = r_out_char;
    assign o_out_last_of_run  = r_out_last;
    assign o_out_forced_flush = r_out_forced;

    assign o_sts.is_ws     = (r_char == CH_SPACE) || (r_char == CH_TAB);
    assign o_sts.is_nl     = (r_char == CH_NEWLINE);
    assign o_sts.eos       = r_eos;
    assign o_sts.lhc       = r_lhc;
    assign o_sts.full      = (r_count == CW'(PENDING_DEPTH));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.count_one = (r_count == CW'(1));
    assign o_sts.out_free  = out_free;

    `ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(PENDING_DEPTH))
    `ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_count != '0)
    `ASSERT_IMPLY(a_push_room, i_clk, i_rst_n,
                  i_cmd.push && (r_count == CW'(PENDING_DEPTH)), i_cmd.pop)

endmodule

>>> src/tws_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tws_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tws_pkg::t_sts i_sts,
    output tws_pkg::t_cmd o_cmd
);
    import tws_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WORK  = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_CHAR  = 3'd3;
    localparam logic [2:0] S_EOS   = 3'd4;

    logic [2:0] r_state, n_state;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_WORK;
                end
            end
            S_WORK: begin
                if (i_sts.is_ws) begin
                    if (i_sts.full) begin
                        if (i_sts.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_sel    = SEL_HEAD;
                            cmd.emit_forced = 1'b1;
                            cmd.emit_last   = !(i_sts.eos && i_sts.lhc);
                            cmd.pop         = 1'b1;
                            cmd.push        = 1'b1;
                            n_state         = i_sts.eos ? S_EOS : S_IDLE;
                        end
                    end else begin
                        cmd.push = 1'b1;
                        n_state  = i_sts.eos ? S_EOS : S_IDLE;
                    end
                end else if (i_sts.is_nl) begin
                    if (!i_sts.lhc) begin
                        cmd.drop = 1'b1;
                        n_state  = S_IDLE;
                    end else if (i_sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = SEL_NL;
                        cmd.emit_last = 1'b1;
                        cmd.drop      = 1'b1;
                        cmd.clr_lhc   = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (!i_sts.empty) begin
                    n_state = S_FLUSH;
                end else if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_CHAR;
                    cmd.emit_last = !i_sts.eos;
                    cmd.set_lhc   = 1'b1;
                    n_state       = i_sts.eos ? S_EOS : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_HEAD;
                    cmd.pop      = 1'b1;
                    if (i_sts.count_one) begin
                        n_state = S_CHAR;
                    end
                end
            end
            S_CHAR: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_CHAR;
                    cmd.emit_last = !i_sts.eos;
                    cmd.set_lhc   = 1'b1;
                    n_state       = i_sts.eos ? S_EOS : S_IDLE;
                end
            end
            S_EOS: begin
                if (!i_sts.lhc) begin
                    cmd.drop = 1'b1;
                    n_state  = S_IDLE;
                end else if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_NL;
                    cmd.emit_last = 1'b1;
                    cmd.drop      = 1'b1;
                    cmd.clr_lhc   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

    `ASSERT_IMPLY(a_emit_has_room, i_clk, i_rst_n, cmd.emit, i_sts.out_free)
    `ASSERT_NEXT(a_accept_to_work, i_clk, i_rst_n, cmd.load_item, r_state == S_WORK)
    `ASSERT_IMPLY(a_flush_has_data, i_clk, i_rst_n, r_state == S_FLUSH, !i_sts.empty)

endmodule

>>> src/trailing_whitespace_stripper.sv
// An item is taken in the idle state and worked in the work state after it; its first
// result is written into the output register, at the earliest, while it is worked.
// A blank or newline needs only the work state; a visible byte first releases its N held
// blanks; end of stream adds a newline state except on a newline. Output stalls add waits.
// The blank queue has a single read port, so held blanks leave one per cycle unless stalled.
// Reset (i_rst_n low, synchronous): queue empty, line state cleared, no output.
`timescale 1ns / 1ps

module trailing_whitespace_stripper #(
    parameter int PENDING_DEPTH = 32  // held blanks, 1 to 62
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_in_end_of_stream,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_last_of_run,
    output logic       o_out_forced_flush
);
    import tws_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // Controller: takes one item at a time and steps through
    // hold / flush / byte / end-of-stream newline.
    tws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: held item, circular blank queue in RAM, line flag and
    // the output register that decouples the two channels.
    tws_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_in_char          (i_in_char),
        .i_in_end_of_stream (i_in_end_of_stream),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_out_char         (o_out_char),
        .o_out_last_of_run  (o_out_last_of_run),
        .o_out_forced_flush (o_out_forced_flush)
    );

    // stalled whenever an item is still being worked
    assign o_in_stall = !in_ready;

endmodule

>>> sim/tb_trailing_whitespace_stripper.sv
`timescale 1ns / 1ps

module tb_trailing_whitespace_stripper;
    import tws_pkg::*;

    localparam int HOLD_DEPTH    = 32;    // blanks the block may hold back
    localparam int ITEMS_PER_LEG = 58;    // random items per idling phase
    localparam int DRAIN_CYCLES  = 8;     // settle time after the last result
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake before giving up

    // How a directed row is checked: typed-in expectation or the predictor.
    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,  // expectations come from the predictor
        ROW_NONE    = 2'd1,  // the item must produce nothing
        ROW_ONE     = 2'd2   // exactly one result, typed in the row
    } t_row_check;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic [5:0] reps;      // the item is sent this many times
        t_row_check chk;
        logic [7:0] want_ch;   // only used by ROW_ONE
        logic       want_early;
    } t_stim_row;

    // One byte of the cleaned stream as the block should emit it.
    typedef struct packed {
        logic [7:0] out_ch;
        logic       run_end;
        logic       early;
    } t_emit;

    localparam int N_ROWS = 25;

    // Directed stimulus. Rows marked ROW_ONE / ROW_NONE carry their answer;
    // the rest are left to the predictor.
    localparam t_stim_row DIRECTED [0:N_ROWS-1] = '{
        // zero byte straight after reset is just a visible byte
        '{8'h00, 1'b0, 6'd1, ROW_ONE, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 6'd1, ROW_ONE, 8'hFF, 1'b0},
        '{CH_NEWLINE, 1'b0, 6'd1, ROW_ONE, CH_NEWLINE, 1'b0},
        // empty line vanishes
        '{CH_NEWLINE, 1'b0, 6'd1, ROW_NONE, 8'h00, 1'b0},
        // blank-only line vanishes too
        '{CH_SPACE, 1'b0, 6'd1, ROW_NONE, 8'h00, 1'b0},
        '{CH_TAB, 1'b0, 6'd1, ROW_NONE, 8'h00, 1'b0},
        '{CH_NEWLINE, 1'b0, 6'd1, ROW_NONE, 8'h00, 1'b0},
        // line whose only visible byte is the first one is kept
        '{8'h61, 1'b0, 6'd1, ROW_ONE, 8'h61, 1'b0},
        '{CH_NEWLINE, 1'b0, 6'd1, ROW_ONE, CH_NEWLINE, 1'b0},
        // leading tab released ahead of a visible byte
        '{CH_TAB, 1'b0, 6'd1, ROW_NONE, 8'h00, 1'b0},
        '{8'h7E, 1'b0, 6'd1, ROW_PREDICT, 8'h00, 1'b0},
        // trailing blank dropped; end of stream on a newline adds nothing
        '{CH_SPACE, 1'b0, 6'd1, ROW_NONE, 8'h00, 1'b0},
        '{CH_NEWLINE, 1'b1, 6'd1, ROW_ONE, CH_NEWLINE, 1'b0},
        // end of stream on an empty line
        '{CH_SPACE, 1'b1, 6'd1, ROW_NONE, 8'h00, 1'b0},
        // end of stream on a visible byte closes the line
        '{8'h41, 1'b1, 6'd1, ROW_PREDICT, 8'h00, 1'b0},
        '{8'h80, 1'b0, 6'd1, ROW_ONE, 8'h80, 1'b0},
        // end of stream on a held blank: blank dropped, line closed
        '{CH_SPACE, 1'b1, 6'd1, ROW_ONE, CH_NEWLINE, 1'b0},
        // fill the store: one tab then 31 spaces
        '{CH_TAB, 1'b0, 6'd1, ROW_NONE, 8'h00, 1'b0},
        '{CH_SPACE, 1'b0, 6'd31, ROW_NONE, 8'h00, 1'b0},
        // store full: oldest (the tab) goes out early, then a space
        '{CH_TAB, 1'b0, 6'd1, ROW_ONE, CH_TAB, 1'b1},
        '{CH_SPACE, 1'b0, 6'd1, ROW_ONE, CH_SPACE, 1'b1},
        // full store released by a visible byte that also ends the stream
        '{8'h5A, 1'b1, 6'd1, ROW_PREDICT, 8'h00, 1'b0},
        // overflow on a fresh line; the early blank is not content
        '{CH_SPACE, 1'b0, 6'd33, ROW_PREDICT, 8'h00, 1'b0},
        '{CH_NEWLINE, 1'b0, 6'd1, ROW_NONE, 8'h00, 1'b0},
        '{8'h3F, 1'b0, 6'd1, ROW_PREDICT, 8'h00, 1'b0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_char = 8'h00;
    logic       i_in_end_of_stream = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_char;
    logic       o_out_last_of_run;
    logic       o_out_forced_flush;

    trailing_whitespace_stripper #(
        .PENDING_DEPTH(HOLD_DEPTH)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_char          (i_in_char),
        .i_in_end_of_stream (i_in_end_of_stream),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_char         (o_out_char),
        .o_out_last_of_run  (o_out_last_of_run),
        .o_out_forced_flush (o_out_forced_flush)
    );

    // idling odds in percent, changed per phase
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;

    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned blank_burst = 0;  // blanks still owed to a long run

    // Predictor state: held blanks oldest first (1 = tab), and whether the
    // current line has shown a visible byte.
    bit    held_tab[$];
    bit    line_active = 1'b0;
    t_emit step_out[$];      // results of the item just taken
    t_emit cleaned_q[$];     // bytes the block still owes us

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Work out what one accepted item makes the block emit.
    task automatic strip_step(input logic [7:0] c, input logic e);
        t_emit r;
        step_out.delete();
        if (c == CH_SPACE || c == CH_TAB) begin
            if (held_tab.size() >= HOLD_DEPTH) begin
                // store full: the oldest blank leaves early, flagged
                r = '{out_ch: held_tab[0] ? CH_TAB : CH_SPACE, run_end: 1'b0, early: 1'b1};
                step_out.push_back(r);
                void'(held_tab.pop_front());
            end
            held_tab.push_back(c == CH_TAB);
        end else if (c == CH_NEWLINE) begin
            held_tab.delete();
            if (line_active) begin
                r = '{out_ch: CH_NEWLINE, run_end: 1'b0, early: 1'b0};
                step_out.push_back(r);
            end
            line_active = 1'b0;
        end else begin
            // visible byte: held run goes first, then the byte itself
            foreach (held_tab[i]) begin
                r = '{out_ch: held_tab[i] ? CH_TAB : CH_SPACE, run_end: 1'b0, early: 1'b0};
                step_out.push_back(r);
            end
            held_tab.delete();
            r = '{out_ch: c, run_end: 1'b0, early: 1'b0};
            step_out.push_back(r);
            line_active = 1'b1;
        end
        if (e) begin
            held_tab.delete();
            if (line_active) begin
                r = '{out_ch: CH_NEWLINE, run_end: 1'b0, early: 1'b0};
                step_out.push_back(r);
            end
            line_active = 1'b0;
        end
        if (step_out.size() != 0)
            step_out[step_out.size() - 1].run_end = 1'b1;
    endtask

    // Offer one item, hold it until taken, then book its expected output.
    task automatic send_byte(input logic [7:0] c, input logic e, input t_row_check chk,
                             input logic [7:0] want_c, input logic want_f);
        t_emit r;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_in_char          <= c;
        i_in_end_of_stream <= e;
        // stall is read as it stood at the edge, before any register update
        do @(posedge i_clk); while (o_in_stall);
        strip_step(c, e);
        case (chk)
            ROW_PREDICT: begin
                foreach (step_out[i]) cleaned_q.push_back(step_out[i]);
            end
            ROW_ONE: begin
                r = '{out_ch: want_c, run_end: 1'b1, early: want_f};
                cleaned_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Text-like random bytes: mostly words, blanks and line breaks, now and
    // then a long blank run to push the store past full.
    task automatic random_byte(output logic [7:0] c, output logic e);
        int unsigned roll;
        roll = $urandom_range(99);
        if (blank_burst == 0 && roll == 0)
            blank_burst = $urandom_range(40, 28);
        if (blank_burst != 0) begin
            blank_burst--;
            c = $urandom_range(3) == 0 ? CH_TAB : CH_SPACE;
        end else if (roll < 48) begin
            c = 8'($urandom_range(255));   // any byte, whitespace included
        end else if (roll < 72) begin
            c = CH_SPACE;
        end else if (roll < 84) begin
            c = CH_TAB;
        end else begin
            c = CH_NEWLINE;
        end
        e = $urandom_range(99) < 3;
    endtask

    // Output side: check each taken byte, then pick the next stall.
    always @(posedge i_clk) begin : out_side
        t_emit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cleaned_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected byte: expected none, actual %0d last %0b forced %0b",
                         $time, o_out_char, o_out_last_of_run, o_out_forced_flush);
            end else begin
                want = cleaned_q.pop_front();
                if (o_out_char !== want.out_ch) begin
                    mismatches++;
                    $display("%0t: out_char mismatch: expected %0d, actual %0d",
                             $time, want.out_ch, o_out_char);
                end
                if (o_out_last_of_run !== want.run_end) begin
                    mismatches++;
                    $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                             $time, want.run_end, o_out_last_of_run);
                end
                if (o_out_forced_flush !== want.early) begin
                    mismatches++;
                    $display("%0t: forced_flush mismatch: expected %0b, actual %0b",
                             $time, want.early, o_out_forced_flush);
                end
            end
        end
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog: too long with neither side moving means the block hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] c;
        logic       e;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        for (int r = 0; r < N_ROWS; r++) begin
            for (int k = 0; k < DIRECTED[r].reps; k++)
                send_byte(DIRECTED[r].ch, DIRECTED[r].eos, DIRECTED[r].chk,
                          DIRECTED[r].want_ch, DIRECTED[r].want_early);
        end

        // random part across the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 69; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 69; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            for (int n = 0; n < ITEMS_PER_LEG; n++) begin
                random_byte(c, e);
                send_byte(c, e, ROW_PREDICT, 8'h00, 1'b0);
            end
        end
        i_in_valid <= 1'b0;

        // drain, then give any stray byte time to show up
        while (cleaned_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/tws_pkg.sv
src/tws_ram.sv
src/tws_datapath.sv
src/tws_ctrl.sv
src/trailing_whitespace_stripper.sv
sim/tb_trailing_whitespace_stripper.sv
